/* hdl/rost_pkg.sv */
package rost_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // distance, parallel threshold and configuration widths
  localparam int T_W        = 47;
  localparam int EPS_W      = 16;
  localparam int CFG_ADDR_W = 3;

  // product magnitude cap 2^60, dot products and dividend
  localparam int PCAP_W = 61;
  localparam int DOT_W  = 63;
  localparam int FMAG_W = DOT_W - 1;
  localparam int NUM_W  = 64;

  localparam logic [PCAP_W-1:0] PROD_CAP = {1'b1, {(PCAP_W-1){1'b0}}};
  localparam logic [T_W:0]      T_CAP    = {1'b1, {T_W{1'b0}}};

  // far limit default 100000.0, parallel threshold 0.001 rounded up
  localparam longint FAR_RESET_INT = 100000;
  localparam longint EPS_SCALE     = 1000;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_EPS   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAR   = 3'd7;

endpackage

/* hdl/rost_in_if.sv */
interface rost_in_if #(
  parameter int COORD_WIDTH = rost_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_pos_x;
  logic signed [COORD_WIDTH-1:0] box_pos_y;
  logic signed [COORD_WIDTH-1:0] box_pos_z;
  logic signed [COORD_WIDTH-1:0] axis_x;
  logic signed [COORD_WIDTH-1:0] axis_y;
  logic signed [COORD_WIDTH-1:0] axis_z;
  logic signed [COORD_WIDTH-1:0] slab_low;
  logic signed [COORD_WIDTH-1:0] slab_high;
  logic                          first_axis;
  logic                          last_axis;

  modport source (
    output valid, box_pos_x, box_pos_y, box_pos_z, axis_x, axis_y, axis_z,
           slab_low, slab_high, first_axis, last_axis,
    input  ready
  );

  modport sink (
    input  valid, box_pos_x, box_pos_y, box_pos_z, axis_x, axis_y, axis_z,
           slab_low, slab_high, first_axis, last_axis,
    output ready
  );
endinterface

/* hdl/rost_out_if.sv */
interface rost_out_if;
  import rost_pkg::*;

  logic           valid;
  logic           ready;
  logic           hit;
  logic [T_W-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

/* hdl/ray_obb_slab_test_unit.sv */
// Flow per axis: a shared-multiplier pass, then, for an axis that is not near-parallel, two
//   divider passes (a saturating quotient skips its steps), then order and clip; a ray that
//   has already missed skips the work. A new axis is taken only once the last one is done.
//   The bit-serial divider uses one shared subtractor over two 47-step passes.
// Reset: synchronous, active low; control and configuration registers take their defaults, no result pending.
module ray_obb_slab_test_unit #(
  parameter int  COORD_WIDTH = rost_pkg::COORD_WIDTH_DEF,
  parameter int  FRAC_BITS   = rost_pkg::FRAC_BITS_DEF,
  localparam int CFG_W       = (COORD_WIDTH > rost_pkg::T_W) ? COORD_WIDTH : rost_pkg::T_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rost_in_if.sink                         in_item,
  rost_out_if.source                      out_item,
  input  logic                            cfg_we,
  input  logic [rost_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]                cfg_wdata
);
  import rost_pkg::*;

  localparam int OP_W   = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int SH_W   = (PROD_W - FRAC_BITS > PCAP_W) ? PROD_W - FRAC_BITS : PCAP_W;
  localparam int TS_W   = T_W + 2;
  localparam int CNT_W  = $clog2(T_W);

  localparam logic [CNT_W-1:0] MUL_ISSUES = CNT_W'(6);
  localparam logic [CNT_W-1:0] ACC_FIRST  = CNT_W'(2);
  localparam logic [CNT_W-1:0] E_LAST     = ACC_FIRST + CNT_W'(2);
  localparam logic [CNT_W-1:0] MUL_LAST   = MUL_ISSUES + CNT_W'(1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(T_W - 1);

  localparam logic [T_W-1:0] FAR_INIT = T_W'(64'(FAR_RESET_INT) << FRAC_BITS);
  localparam logic [EPS_W-1:0] EPS_INIT =
    EPS_W'(((64'd1 << FRAC_BITS) + 64'(EPS_SCALE) - 64'd1) / 64'(EPS_SCALE));
  localparam logic signed [COORD_WIDTH-1:0] DIR_UNIT = COORD_WIDTH'(64'd1 << FRAC_BITS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_FABS   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DMAG   = 4'd5;
  localparam logic [3:0] S_DINIT  = 4'd6;
  localparam logic [3:0] S_DSTEP  = 4'd7;
  localparam logic [3:0] S_DDONE  = 4'd8;
  localparam logic [3:0] S_ORDER  = 4'd9;
  localparam logic [3:0] S_CLIP   = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic signed [COORD_WIDTH-1:0] org_r [3];
  logic signed [COORD_WIDTH-1:0] dir_r [3];
  logic [EPS_W-1:0]              eps_r;
  logic [T_W-1:0]                far_r;

  logic signed [OP_W-1:0]        delta_r [3];
  logic signed [COORD_WIDTH-1:0] axis_r  [3];
  logic signed [COORD_WIDTH-1:0] slab_lo_r, slab_hi_r;
  logic                          last_r;

  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        pmag_r;
  logic                     pneg_r;
  logic signed [DOT_W-1:0]  e_r, f_r;
  logic [FMAG_W-1:0]        fmag_r;
  logic                     fneg_r;

  logic                    sel_r;
  logic signed [NUM_W-1:0] num_r;
  logic [NUM_W-1:0]        un_r;
  logic                    nneg_r;
  logic [FMAG_W-1:0]       rem_r;
  logic [T_W-1:0]          low_r;
  logic [T_W:0]            q_r;
  logic signed [TS_W-1:0]  t1_r, t2_r, tlo_r, thi_r;

  logic [T_W-1:0] near_r, far_cur_r;
  logic           missed_r;

  logic           out_valid_r, hit_r;
  logic [T_W-1:0] dist_r;

  logic                    in_acc, emit;
  logic signed [OP_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SH_W-1:0]         sh;
  logic [PCAP_W-1:0]       tmag;
  logic signed [DOT_W-1:0] term, acc_in, acc_sum;
  logic signed [DOT_W-1:0] lo_ext, hi_ext;
  logic                    par_miss, steep;
  logic [NUM_W-1:0]        div_hi;
  logic                    div_sat;
  logic [FMAG_W:0]         shifted;
  logic                    qbit;
  logic [FMAG_W-1:0]       rem_next;
  logic signed [TS_W-1:0]  q_signed, near_ext, far_ext, nn, nf;
  logic                    clip_empty;

  assign in_acc        = in_item.valid && in_item.ready;
  assign in_item.ready = (state_r == S_IDLE);
  assign emit          = (state_r == S_FINISH) && last_r && (!out_valid_r || out_item.ready);

  assign out_item.valid    = out_valid_r;
  assign out_item.hit      = hit_r;
  assign out_item.distance = dist_r;

  // shared multiplier: three axis . delta products, then three dir . axis
  always_comb begin
    case (cnt_r)
      CNT_W'(0): begin
        mul_a = OP_W'(axis_r[0]);
        mul_b = delta_r[0];
      end
      CNT_W'(1): begin
        mul_a = OP_W'(axis_r[1]);
        mul_b = delta_r[1];
      end
      CNT_W'(2): begin
        mul_a = OP_W'(axis_r[2]);
        mul_b = delta_r[2];
      end
      CNT_W'(3): begin
        mul_a = OP_W'(dir_r[0]);
        mul_b = OP_W'(axis_r[0]);
      end
      CNT_W'(4): begin
        mul_a = OP_W'(dir_r[1]);
        mul_b = OP_W'(axis_r[1]);
      end
      CNT_W'(5): begin
        mul_a = OP_W'(dir_r[2]);
        mul_b = OP_W'(axis_r[2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign sh      = SH_W'(pmag_r >> FRAC_BITS);
  assign tmag    = (sh > SH_W'(PROD_CAP)) ? PROD_CAP : sh[PCAP_W-1:0];
  assign term    = $signed({{(DOT_W-PCAP_W){1'b0}}, tmag});
  assign acc_in  = (cnt_r <= E_LAST) ? e_r : f_r;
  assign acc_sum = pneg_r ? acc_in - term : acc_in + term;

  assign lo_ext   = {{(DOT_W-COORD_WIDTH){slab_lo_r[COORD_WIDTH-1]}}, slab_lo_r};
  assign hi_ext   = {{(DOT_W-COORD_WIDTH){slab_hi_r[COORD_WIDTH-1]}}, slab_hi_r};
  assign par_miss = (lo_ext > e_r) || (hi_ext < e_r);
  assign steep    = fmag_r > FMAG_W'(eps_r);

  // restoring divider; quotient clamps at 2^47 when the top part already reaches |f|
  assign div_hi   = un_r >> (T_W - FRAC_BITS);
  assign div_sat  = div_hi >= NUM_W'(fmag_r);
  assign shifted  = {rem_r, low_r[T_W-1]};
  assign qbit     = shifted >= {1'b0, fmag_r};
  assign rem_next = FMAG_W'(qbit ? shifted - {1'b0, fmag_r} : shifted);
  assign q_signed = (nneg_r ^ fneg_r) ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  assign near_ext   = $signed({2'b00, near_r});
  assign far_ext    = $signed({2'b00, far_cur_r});
  assign nn         = (tlo_r > near_ext) ? tlo_r : near_ext;
  assign nf         = (thi_r < far_ext) ? thi_r : far_ext;
  assign clip_empty = nf < nn;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == '0 && missed_r) state_nxt = S_FINISH;
        else if (cnt_r == MUL_LAST)  state_nxt = S_FABS;
      end
      S_FABS:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = steep ? S_DLOAD : S_FINISH;
      S_DLOAD:  state_nxt = S_DMAG;
      S_DMAG:   state_nxt = S_DINIT;
      S_DINIT:  state_nxt = div_sat ? S_DDONE : S_DSTEP;
      S_DSTEP:  if (cnt_r == DIV_LAST) state_nxt = S_DDONE;
      S_DDONE:  state_nxt = sel_r ? S_ORDER : S_DLOAD;
      S_ORDER:  state_nxt = S_CLIP;
      S_CLIP:   state_nxt = S_FINISH;
      S_FINISH: if (!last_r || !out_valid_r || out_item.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      org_r[0]    <= '0;
      org_r[1]    <= '0;
      org_r[2]    <= '0;
      dir_r[0]    <= '0;
      dir_r[1]    <= '0;
      dir_r[2]    <= DIR_UNIT;
      eps_r       <= EPS_INIT;
      far_r       <= FAR_INIT;
      near_r      <= '0;
      far_cur_r   <= FAR_INIT;
      missed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ORG_X: org_r[0] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_ORG_Y: org_r[1] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_ORG_Z: org_r[2] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_X: dir_r[0] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_Y: dir_r[1] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_Z: dir_r[2] <= cfg_wdata[COORD_WIDTH-1:0];
          CFG_EPS:   eps_r    <= cfg_wdata[EPS_W-1:0];
          CFG_FAR:   far_r    <= cfg_wdata[T_W-1:0];
        endcase
      end

      if (in_acc) begin
        cnt_r <= '0;
      end else if (state_r == S_MUL || state_r == S_DSTEP) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (state_r == S_DINIT) begin
        cnt_r <= '0;
      end

      if (in_acc && in_item.first_axis) begin
        near_r    <= '0;
        far_cur_r <= far_r;
        missed_r  <= 1'b0;
      end else if (state_r == S_DECIDE && !steep && par_miss) begin
        missed_r <= 1'b1;
      end else if (state_r == S_CLIP) begin
        if (clip_empty) begin
          missed_r <= 1'b1;
        end else begin
          near_r    <= nn[T_W-1:0];
          far_cur_r <= nf[T_W-1:0];
        end
      end

      if (emit)                out_valid_r <= 1'b1;
      else if (out_item.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      delta_r[0] <= OP_W'(in_item.box_pos_x) - OP_W'(org_r[0]);
      delta_r[1] <= OP_W'(in_item.box_pos_y) - OP_W'(org_r[1]);
      delta_r[2] <= OP_W'(in_item.box_pos_z) - OP_W'(org_r[2]);
      axis_r[0]  <= in_item.axis_x;
      axis_r[1]  <= in_item.axis_y;
      axis_r[2]  <= in_item.axis_z;
      slab_lo_r  <= in_item.slab_low;
      slab_hi_r  <= in_item.slab_high;
      last_r     <= in_item.last_axis;
      e_r        <= '0;
      f_r        <= '0;
      sel_r      <= 1'b0;
    end

    if (state_r == S_MUL) begin
      prod_r <= prod;
      pmag_r <= prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
      pneg_r <= prod_r[PROD_W-1];
      if (cnt_r >= ACC_FIRST) begin
        if (cnt_r <= E_LAST) e_r <= acc_sum;
        else                 f_r <= acc_sum;
      end
    end

    if (state_r == S_FABS) begin
      fmag_r <= FMAG_W'(f_r[DOT_W-1] ? -f_r : f_r);
      fneg_r <= f_r[DOT_W-1];
    end

    if (state_r == S_DLOAD) begin
      num_r <= {e_r[DOT_W-1], e_r} + (sel_r ? NUM_W'(slab_hi_r) : NUM_W'(slab_lo_r));
    end

    if (state_r == S_DMAG) begin
      un_r   <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
      nneg_r <= num_r[NUM_W-1];
    end

    if (state_r == S_DINIT) begin
      if (div_sat) begin
        q_r <= T_CAP;
      end else begin
        q_r   <= '0;
        rem_r <= FMAG_W'(div_hi);
        low_r <= T_W'(un_r << FRAC_BITS);
      end
    end

    if (state_r == S_DSTEP) begin
      rem_r <= rem_next;
      low_r <= {low_r[T_W-2:0], 1'b0};
      q_r   <= {q_r[T_W-1:0], qbit};
    end

    if (state_r == S_DDONE) begin
      if (sel_r) t2_r <= q_signed;
      else       t1_r <= q_signed;
      sel_r <= 1'b1;
    end

    if (state_r == S_ORDER) begin
      tlo_r <= (t1_r > t2_r) ? t2_r : t1_r;
      thi_r <= (t1_r > t2_r) ? t1_r : t2_r;
    end

    if (emit) begin
      hit_r  <= !missed_r;
      dist_r <= missed_r ? '0 : near_r;
    end
  end

endmodule

/* hdl/rost_checker.sv */
module rost_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic [rost_pkg::T_W-1:0] out_distance
);
  import rost_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_distance))
    else $error("result changed while stalled");

  // busy after every input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an axis is in flight");

  // a new result only comes out of a busy spell
  a_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == {T_W{1'b0}})
    else $error("miss with non-zero distance");

endmodule

bind ray_obb_slab_test_unit rost_checker u_rost_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_hit      (out_item.hit),
  .out_distance (out_item.distance)
);

/* sim/slab_hit_checker.sv */
module slab_hit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  rost_in_if                              in_mon,
  rost_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [rost_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rost_pkg::T_W-1:0]        cfg_wdata,
  output int                              pending,
  output int                              error_count
);
  import rost_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CW   = COORD_WIDTH_DEF;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] distance;
  } slab_result_t;

  slab_result_t     expected_hits[$];
  longint           org_x, org_y, org_z;
  longint           dir_x, dir_y, dir_z;
  logic [EPS_W-1:0] eps_reg;
  logic [T_W-1:0]   far_reg;
  longint           near_t, far_t;
  logic             missed_ray;
  int               mismatches = 0;
  int               result_index = 0;

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("MISMATCH %s at result %0d: expected %0d, got %0d", what, result_index, want, got);
  endtask

  // product magnitude truncated to Q16.16 and capped at 2^60
  function automatic longint fx_mul(input longint a, input longint b);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    longint       r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod >> FRAC;
    if (prod > 128'(PROD_CAP)) prod = 128'(PROD_CAP);
    r = longint'(prod[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // quotient magnitude truncated, capped at 2^47
  function automatic longint fx_div(input longint num, input longint den);
    logic [63:0]  mn, md;
    logic [127:0] quo;
    longint       r;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    quo = ({64'd0, mn} << FRAC) / {64'd0, md};
    if (quo > 128'(T_CAP)) quo = 128'(T_CAP);
    r = longint'(quo[63:0]);
    return ((num < 0) != (den < 0)) ? -r : r;
  endfunction

  // one box axis against the running interval; returns 1 when a result is due
  function automatic bit clip_axis(input longint px, py, pz, ax, ay, az, lo, hi,
                                   input bit first, last, output slab_result_t res);
    longint      e, f, t1, t2, nn, nf, sw;
    logic [63:0] f_mag;
    if (first) begin
      near_t = 0;
      far_t = {17'd0, far_reg};
      missed_ray = 1'b0;
    end
    if (!missed_ray) begin
      e = fx_mul(ax, px - org_x) + fx_mul(ay, py - org_y) + fx_mul(az, pz - org_z);
      f = fx_mul(dir_x, ax) + fx_mul(dir_y, ay) + fx_mul(dir_z, az);
      f_mag = (f < 0) ? -f : f;
      if (f_mag > 64'(eps_reg)) begin
        t1 = fx_div(e + lo, f);
        t2 = fx_div(e + hi, f);
        if (t1 > t2) begin
          sw = t1;
          t1 = t2;
          t2 = sw;
        end
        nf = (t2 < far_t) ? t2 : far_t;
        nn = (t1 > near_t) ? t1 : near_t;
        // an emptied interval keeps its old bounds
        if (nf < nn) begin
          missed_ray = 1'b1;
        end else begin
          near_t = nn;
          far_t = nf;
        end
      end else if (lo - e > 0 || hi - e < 0) begin
        missed_ray = 1'b1;
      end
    end
    res.hit = !missed_ray;
    res.distance = missed_ray ? '0 : near_t[T_W-1:0];
    return last;
  endfunction

  always @(posedge clk) begin : watch
    slab_result_t want, fresh;
    if (!rst_n) begin
      org_x = 0;
      org_y = 0;
      org_z = 0;
      dir_x = 0;
      dir_y = 0;
      dir_z = longint'(1) << FRAC;
      eps_reg = 16'd66;
      far_reg = T_W'(FAR_RESET_INT << FRAC);
      near_t = 0;
      far_t = {17'd0, far_reg};
      missed_ray = 1'b0;
      expected_hits.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result, distance", 0, longint'(out_mon.distance));
        end else begin
          want = expected_hits.pop_front();
          if (out_mon.hit !== want.hit) begin
            report_mismatch("hit", longint'(want.hit), longint'(out_mon.hit));
          end
          if (out_mon.distance !== want.distance) begin
            report_mismatch("distance", longint'(want.distance), longint'(out_mon.distance));
          end
        end
        result_index++;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORG_X: org_x = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_ORG_Y: org_y = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_ORG_Z: org_z = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_DIR_X: dir_x = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_DIR_Y: dir_y = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_DIR_Z: dir_z = longint'($signed(cfg_wdata[CW-1:0]));
          CFG_EPS:   eps_reg = cfg_wdata[EPS_W-1:0];
          CFG_FAR:   far_reg = cfg_wdata[T_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (clip_axis(in_mon.box_pos_x, in_mon.box_pos_y, in_mon.box_pos_z,
                      in_mon.axis_x, in_mon.axis_y, in_mon.axis_z,
                      in_mon.slab_low, in_mon.slab_high,
                      in_mon.first_axis, in_mon.last_axis, fresh)) begin
          expected_hits.push_back(fresh);
        end
      end
    end
    pending <= expected_hits.size();
    error_count <= mismatches;
  end

endmodule

/* sim/ray_obb_slab_test_unit_test.sv */
module ray_obb_slab_test_unit_test;
  import rost_pkg::*;

  localparam int CFG_W        = (COORD_WIDTH_DEF > T_W) ? COORD_WIDTH_DEF : T_W;
  localparam int ONE          = 1 << FRAC_BITS_DEF;
  localparam int MAXC         = 32'h7FFF_FFFF;
  localparam int MINC         = 32'h8000_0000;
  localparam int DRAIN_CYCLES = 160;
  localparam int IDLE_LIMIT   = 3000;
  localparam int N_PHASES     = 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  int                    pending;
  int                    errors;
  int                    items_sent = 0;
  int                    idle_cycles = 0;
  bit                    steady = 1'b0;
  int                    cur_org[3];
  int                    cur_dir[3];

  rost_in_if  in_bus ();
  rost_out_if out_bus ();

  ray_obb_slab_test_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_bus),
    .out_item  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  slab_hit_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .error_count (errors)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin : sink_side
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
    end
  end

  function automatic int spread(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [CFG_W-1:0] widen(input logic [31:0] v);
    return {{(CFG_W-32){v[31]}}, v};
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // axes with no result may still be in flight once the queue is empty
  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_ray(input int kind);
    int               i, v;
    logic [EPS_W-1:0] eps;
    logic [T_W-1:0]   far;
    logic [63:0]      r64;
    for (i = 0; i < 3; i++) begin
      case (kind)
        1:       v = MAXC;
        2:       v = MINC;
        default: v = spread(20 * ONE);
      endcase
      cur_org[i] = v;
      cfg_write(CFG_ORG_X + 3'(i), widen(v));
    end
    for (i = 0; i < 3; i++) begin
      case (kind)
        1: v = MAXC;
        2: v = MINC;
        default: begin
          case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
            2:       v = spread(2 * ONE);
            default: v = spread(1 << 12);
          endcase
        end
      endcase
      cur_dir[i] = v;
      cfg_write(CFG_DIR_X + 3'(i), widen(v));
    end
    r64 = {$urandom, $urandom};
    case (kind)
      1: begin
        eps = '1;
        far = '1;
      end
      2: begin
        eps = '0;
        far = '0;
      end
      default: begin
        case ($urandom_range(0, 4))
          0, 1:    eps = 16'd66;
          2:       eps = 16'($urandom_range(0, 4095));
          3:       eps = '0;
          default: eps = '1;
        endcase
        case ($urandom_range(0, 4))
          0:       far = T_W'(FAR_RESET_INT << FRAC_BITS_DEF);
          1:       far = T_W'($urandom_range(1, 64)) << FRAC_BITS_DEF;
          2:       far = r64[T_W-1:0];
          3:       far = '0;
          default: far = '1;
        endcase
      end
    endcase
    cfg_write(CFG_EPS, CFG_W'(eps));
    cfg_write(CFG_FAR, CFG_W'(far));
    cfg_we <= 1'b0;
  endtask

  task automatic send_axis(input int px, py, pz, ax, ay, az, lo, hi, input bit first, last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.box_pos_x <= px;
    in_bus.box_pos_y <= py;
    in_bus.box_pos_z <= pz;
    in_bus.axis_x <= ax;
    in_bus.axis_y <= ay;
    in_bus.axis_z <= az;
    in_bus.slab_low <= lo;
    in_bus.slab_high <= hi;
    in_bus.first_axis <= first;
    in_bus.last_axis <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // mostly whole boxes placed along the ray, some loose data, some stray markers
  task automatic send_ray();
    int mode, n, k, rot, sel, sgn, i, cx, cy, cz, ax, ay, az, lo, hi, tmp;
    mode = $urandom_range(0, 19);
    if (mode >= 18) begin
      send_axis($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    end else begin
      n = (mode < 13 && $urandom_range(0, 3) != 0) ? 3 : $urandom_range(1, 6);
      k = $urandom_range(0, 40);
      rot = $urandom_range(0, 2);
      if (mode < 13) begin
        cx = cur_org[0] + cur_dir[0] * k + spread(2 * ONE);
        cy = cur_org[1] + cur_dir[1] * k + spread(2 * ONE);
        cz = cur_org[2] + cur_dir[2] * k + spread(2 * ONE);
      end else if (mode < 16) begin
        cx = spread(1 << 20);
        cy = spread(1 << 20);
        cz = spread(1 << 20);
      end else begin
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
      end
      for (i = 0; i < n; i++) begin
        if (mode < 13) begin
          sel = (i + rot) % 3;
          sgn = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
          ax = (sel == 0) ? sgn : 0;
          ay = (sel == 1) ? sgn : 0;
          az = (sel == 2) ? sgn : 0;
          if ($urandom_range(0, 3) == 0) begin
            ax += spread(ONE / 4);
            ay += spread(ONE / 4);
            az += spread(ONE / 4);
          end
          lo = -int'($urandom_range(ONE / 4, 8 * ONE));
          hi = $urandom_range(ONE / 4, 8 * ONE);
          if ($urandom_range(0, 9) == 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
        end else if (mode < 16) begin
          ax = spread(1 << 20);
          ay = spread(1 << 20);
          az = spread(1 << 20);
          lo = spread(1 << 20);
          hi = spread(1 << 20);
        end else begin
          ax = $urandom;
          ay = $urandom;
          az = $urandom;
          lo = $urandom;
          hi = $urandom;
        end
        send_axis(cx, cy, cz, ax, ay, az, lo, hi, i == 0, i == n - 1);
      end
    end
  endtask

  initial begin : stimulus
    int p, kind, quota, start, rays;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.box_pos_x <= '0;
    in_bus.box_pos_y <= '0;
    in_bus.box_pos_z <= '0;
    in_bus.axis_x <= '0;
    in_bus.axis_y <= '0;
    in_bus.axis_z <= '0;
    in_bus.slab_low <= '0;
    in_bus.slab_high <= '0;
    in_bus.first_axis <= 1'b0;
    in_bus.last_axis <= 1'b0;
    cur_org = '{0, 0, 0};
    cur_dir = '{0, 0, ONE};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: origin 0, direction +z, threshold 66
    send_axis(0, 0, 0, 0, 0, ONE, -ONE, ONE, 1, 1);
    send_axis(0, 0, 10 * ONE, 0, 0, ONE, -ONE, ONE, 1, 1);
    send_axis(0, 0, -10 * ONE, 0, 0, ONE, -ONE, ONE, 1, 1);
    send_axis(0, 0, 0, ONE, 0, 0, -ONE, ONE, 1, 1);
    // parallel miss, then latched through the rest of the ray
    send_axis(5 * ONE, 0, 0, ONE, 0, 0, -ONE, ONE, 1, 0);
    send_axis(0, 0, 10 * ONE, 0, 0, ONE, -ONE, ONE, 0, 0);
    send_axis(0, 0, 10 * ONE, 0, 0, ONE, -ONE, ONE, 0, 1);
    send_axis(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1, 1);
    send_axis(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 1, 1);
    send_axis(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, 1, 1);
    // threshold edge
    send_axis(0, 0, 0, 0, 0, 66, -ONE, ONE, 1, 1);
    send_axis(0, 0, 0, 0, 0, 67, ONE, 2 * ONE, 1, 1);
    send_axis(0, 0, 0, 0, 0, -66, ONE, 2 * ONE, 1, 1);
    send_axis(0, 0, 0, 0, 0, -67, -2 * ONE, -ONE, 1, 1);
    // last with no first: carries the previous interval
    send_axis(0, 0, 10 * ONE, 0, 0, ONE, -3 * ONE, 3 * ONE, 0, 1);
    // disjoint slabs: interval kept, miss set
    send_axis(0, 0, 10 * ONE, 0, 0, ONE, -ONE, ONE, 1, 0);
    send_axis(0, 0, 10 * ONE, 0, ONE, 0, -ONE, ONE, 0, 0);
    send_axis(0, 0, 21 * ONE, 0, 0, ONE, -ONE, ONE, 0, 1);
    // bounds given high before low
    send_axis(0, 0, 10 * ONE, 0, 0, -ONE, ONE, -ONE, 1, 1);
    // quotient saturation
    send_axis(MAXC, 0, 0, MAXC, 0, 67, MINC, MAXC, 1, 1);

    rays = 0;
    for (p = 0; p < N_PHASES; p++) begin
      settle();
      kind = (p == 1) ? 1 : (p == 4) ? 2 : 0;
      program_ray(kind);
      steady = (p % 3 == 2);
      quota = (kind == 0) ? 75 : 25;
      start = items_sent;
      while (items_sent - start < quota) begin
        if (rays % 17 == 5) hold_until_drained();
        send_ray();
        rays++;
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
